/* sv/ipie_pkg.sv */
// Package for the ICMP probe identifier extractor.
// Holds the item and result types and the ICMP/IPv4 protocol constants.
// No dependencies.
package ipie_pkg;

  localparam logic [3:0] IPV4_VERSION     = 4'd4;
  localparam int         MIN_IHL_BYTES    = 20;
  localparam int         ICMP_HDR_BYTES   = 8;
  localparam logic [7:0] PROTO_ICMP       = 8'd1;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

  localparam int MSG_OFS_ID_HI     = 4;
  localparam int MSG_OFS_ID_LO     = 5;
  localparam int MSG_OFS_INNER_IP  = 8;
  localparam int MSG_OFS_INNER_PRO = 17;

  typedef logic [10:0] msg_len_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        packet_ok;
    logic        id_found;
    logic [15:0] probe_id;
    logic [7:0]  message_type;
    logic [5:0]  message_offset;
    msg_len_t    message_length;
  } result_t;

endpackage

/* sv/ipie_if.sv */
// Byte and result channels of the ICMP probe identifier extractor.
// Each carries valid, ready and the payload; depends on ipie_pkg.
interface ipie_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipie_result_if;
  logic                 valid;
  logic                 ready;
  logic                 packet_ok;
  logic                 id_found;
  logic [15:0]          probe_id;
  logic [7:0]           message_type;
  logic [5:0]           message_offset;
  ipie_pkg::msg_len_t   message_length;

  modport source (output valid, output packet_ok, output id_found, output probe_id,
                  output message_type, output message_offset, output message_length,
                  input ready);
  modport sink (input valid, input packet_ok, input id_found, input probe_id,
                input message_type, input message_offset, input message_length,
                output ready);
endinterface

/* sv/ipie_in_stage.sv */
// Input register of the ICMP probe identifier extractor.
// Holds one received byte until the parser advances; depends on ipie_pkg.
module ipie_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ipie_pkg::in_item_t item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output ipie_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  ipie_pkg::in_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/ipie_parser.sv */
// Per-packet parse state and result logic of the ICMP probe identifier extractor.
// Tracks byte position, outer and quoted headers; depends on ipie_pkg.
module ipie_parser #(
  parameter int MAX_PACKET_BYTES = 1536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  ipie_pkg::in_item_t item_i,
  output ipie_pkg::result_t  result_o
);

  localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
  typedef logic [PosW-1:0] pos_t;

  localparam pos_t MaxPos    = pos_t'(MAX_PACKET_BYTES);
  localparam pos_t MinIhl    = pos_t'(ipie_pkg::MIN_IHL_BYTES);
  localparam pos_t HdrBytes  = pos_t'(ipie_pkg::ICMP_HDR_BYTES);
  localparam pos_t MinInner  = pos_t'(ipie_pkg::MIN_IHL_BYTES + ipie_pkg::ICMP_HDR_BYTES);
  localparam pos_t IdHiOfs   = pos_t'(ipie_pkg::ICMP_HDR_BYTES + ipie_pkg::MSG_OFS_ID_HI);
  localparam pos_t IdLoOfs   = pos_t'(ipie_pkg::ICMP_HDR_BYTES + ipie_pkg::MSG_OFS_ID_LO);
  localparam pos_t InnerSpan = pos_t'(2 * ipie_pkg::ICMP_HDR_BYTES);

  pos_t        pos_q, pos_d;
  logic        ipv4_q, ipv4_d;
  logic [5:0]  ohl_q, ohl_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] echo_id_q, echo_id_d;
  logic [5:0]  ihl_q, ihl_d;
  logic        chk_q, chk_d;
  logic [15:0] inner_id_q, inner_id_d;

  pos_t       start, rel, n, len;
  logic [7:0] b;
  logic       ok, found;
  logic [5:0] offset;
  logic [7:0] msg_type;
  logic [15:0] id;

  assign b = item_i.data_byte;

  always_comb begin
    pos_d      = pos_q;
    ipv4_d     = ipv4_q;
    ohl_d      = ohl_q;
    type_d     = type_q;
    echo_id_d  = echo_id_q;
    ihl_d      = ihl_q;
    chk_d      = chk_q;
    inner_id_d = inner_id_q;
    start      = '0;
    rel        = '0;
    if (pos_q < MaxPos) begin
      if (pos_q == '0) begin
        ipv4_d = (b[7:4] == ipie_pkg::IPV4_VERSION);
        ohl_d  = {b[3:0], 2'b00};
      end
      start = (ipv4_d && pos_t'(ohl_d) >= MinIhl) ? pos_t'(ohl_d) : '0;
      if (pos_q >= start) begin
        rel = pos_q - start;
        if (rel == '0) begin
          type_d = b;
        end
        if (rel == pos_t'(ipie_pkg::MSG_OFS_ID_HI)) begin
          echo_id_d[15:8] = b;
        end
        if (rel == pos_t'(ipie_pkg::MSG_OFS_ID_LO)) begin
          echo_id_d[7:0] = b;
        end
        if (rel == pos_t'(ipie_pkg::MSG_OFS_INNER_IP)) begin
          ihl_d = {b[3:0], 2'b00};
          chk_d = (b[7:4] == ipie_pkg::IPV4_VERSION) && (pos_t'(ihl_d) >= MinIhl);
        end
        if (rel == pos_t'(ipie_pkg::MSG_OFS_INNER_PRO)) begin
          chk_d = chk_q && (b == ipie_pkg::PROTO_ICMP);
        end
        if (rel >= HdrBytes && pos_t'(ihl_d) >= MinIhl) begin
          if (rel == pos_t'(ihl_d) + IdHiOfs) begin
            inner_id_d[15:8] = b;
          end
          if (rel == pos_t'(ihl_d) + IdLoOfs) begin
            inner_id_d[7:0] = b;
          end
        end
      end
      pos_d = pos_q + pos_t'(1);
    end
  end

  always_comb begin
    n        = pos_d;
    ok       = 1'b0;
    found    = 1'b0;
    offset   = '0;
    msg_type = '0;
    id       = '0;
    len      = '0;
    if (n >= HdrBytes) begin
      if (ipv4_d && n >= MinIhl) begin
        if (pos_t'(ohl_d) >= MinIhl && pos_t'(ohl_d) + HdrBytes <= n) begin
          ok       = 1'b1;
          offset   = ohl_d;
          msg_type = type_d;
        end
      end else begin
        ok       = 1'b1;
        msg_type = ipv4_d ? {ipie_pkg::IPV4_VERSION, ohl_d[5:2]} : type_d;
      end
    end
    if (ok) begin
      len = n - pos_t'(offset);
      if (msg_type == ipie_pkg::TYPE_ECHO_REPLY) begin
        found = 1'b1;
        id    = echo_id_d;
      end else if (msg_type == ipie_pkg::TYPE_DEST_UNREACH ||
                   msg_type == ipie_pkg::TYPE_TIME_EXCEEDED) begin
        if (len >= MinInner && chk_d && pos_t'(ihl_d) + InnerSpan <= len) begin
          found = 1'b1;
          id    = inner_id_d;
        end
      end
    end
  end

  assign result_o.packet_ok      = ok;
  assign result_o.id_found       = found;
  assign result_o.probe_id       = id;
  assign result_o.message_type   = msg_type;
  assign result_o.message_offset = offset;
  assign result_o.message_length = ipie_pkg::msg_len_t'(len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ipv4_q     <= 1'b0;
      ohl_q      <= '0;
      type_q     <= '0;
      echo_id_q  <= '0;
      ihl_q      <= '0;
      chk_q      <= 1'b0;
      inner_id_q <= '0;
    end else if (fire_i) begin
      if (item_i.last_byte) begin
        pos_q      <= '0;
        ipv4_q     <= 1'b0;
        ohl_q      <= '0;
        type_q     <= '0;
        echo_id_q  <= '0;
        ihl_q      <= '0;
        chk_q      <= 1'b0;
        inner_id_q <= '0;
      end else begin
        pos_q      <= pos_d;
        ipv4_q     <= ipv4_d;
        ohl_q      <= ohl_d;
        type_q     <= type_d;
        echo_id_q  <= echo_id_d;
        ihl_q      <= ihl_d;
        chk_q      <= chk_d;
        inner_id_q <= inner_id_d;
      end
    end
  end

endmodule

/* sv/ipie_out_reg.sv */
// Result register of the ICMP probe identifier extractor.
// Holds one packet result until the receiver takes it; depends on ipie_pkg.
module ipie_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ipie_pkg::result_t result_i,
  input  logic              ready_i,
  output logic              valid_o,
  output ipie_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  ipie_pkg::result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* sv/icmp_probe_id_extractor.sv */
// ICMP probe identifier extractor, top level.
// Depends on ipie_pkg, ipie_if, ipie_in_stage, ipie_parser and ipie_out_reg.
//
// byte_i takes a received IPv4 ICMP packet one byte per transfer, last_byte
// set on its final byte. Each packet yields exactly one transfer on result_o,
// made when its last byte is parsed: packet_ok, id_found, probe_id (echo
// reply id or id from the quoted ICMP header of an error), message type,
// offset and length. Bytes past MAX_PACKET_BYTES are counted out of parsing.
//
// Throughput: one byte per cycle, sustained, across packet boundaries, unless a
// stalled result_o holds a final byte. A last byte passes the input register,
// then the parse logic into the result register, before it shows on result_o.
// When result_o is stalled with a result pending, non-final bytes keep
// flowing; a final byte waits in the input register, and byte_i.ready drops
// only while that register is occupied.
// Reset clears the parse state and both valid flags; no result is pending
// afterward and the next byte starts a new packet.
module icmp_probe_id_extractor #(
  parameter int MAX_PACKET_BYTES = 1536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ipie_byte_if.sink            byte_i,
  ipie_result_if.source        result_o
);

  ipie_pkg::in_item_t in_item, st_item;
  ipie_pkg::result_t  parse_res, out_res;
  logic               st_valid, advance, fire, out_valid;

  assign in_item.data_byte = byte_i.data_byte;
  assign in_item.last_byte = byte_i.last_byte;

  assign advance = !st_item.last_byte || !out_valid || result_o.ready;
  assign fire    = st_valid && advance;

  ipie_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (byte_i.valid),
    .ready_o   (byte_i.ready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (st_valid),
    .item_o    (st_item)
  );

  ipie_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (st_item),
    .result_o (parse_res)
  );

  ipie_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && st_item.last_byte),
    .result_i (parse_res),
    .ready_i  (result_o.ready),
    .valid_o  (out_valid),
    .result_o (out_res)
  );

  assign result_o.valid          = out_valid;
  assign result_o.packet_ok      = out_res.packet_ok;
  assign result_o.id_found       = out_res.id_found;
  assign result_o.probe_id       = out_res.probe_id;
  assign result_o.message_type   = out_res.message_type;
  assign result_o.message_offset = out_res.message_offset;
  assign result_o.message_length = out_res.message_length;

endmodule

/* sv/ipie_checker.sv */
// Port checker for the ICMP probe identifier extractor, bound to the top level.
// Watches the result channel only; depends on ipie_pkg.
module ipie_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic               packet_ok_i,
  input logic               id_found_i,
  input logic [15:0]        probe_id_i,
  input logic [7:0]         message_type_i,
  input logic [5:0]         message_offset_i,
  input ipie_pkg::msg_len_t message_length_i
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(probe_id_i) &&
    $stable(packet_ok_i) && $stable(message_length_i))
    else $error("result changed while stalled");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !packet_ok_i |-> !id_found_i && probe_id_i == '0 &&
    message_type_i == '0 && message_offset_i == '0 && message_length_i == '0)
    else $error("dropped packet with nonzero fields");

  a_id_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && id_found_i |-> packet_ok_i)
    else $error("id found on dropped packet");

  a_offset_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_ok_i && message_offset_i != '0 |->
    message_offset_i >= 6'(ipie_pkg::MIN_IHL_BYTES) &&
    message_length_i >= ipie_pkg::msg_len_t'(ipie_pkg::ICMP_HDR_BYTES))
    else $error("bad header offset or short message");

endmodule

bind icmp_probe_id_extractor ipie_checker u_ipie_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .packet_ok_i      (result_o.packet_ok),
  .id_found_i       (result_o.id_found),
  .probe_id_i       (result_o.probe_id),
  .message_type_i   (result_o.message_type),
  .message_offset_i (result_o.message_offset),
  .message_length_i (result_o.message_length)
);
